FILE: src/rmfa_pkg.sv
package rmfa_pkg;

	localparam int COEF_WIDTH_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam logic [1:0] CMD_AXIS  = 2'd0;
	localparam logic [1:0] CMD_XYZ   = 2'd1;
	localparam logic [1:0] CMD_YXZ   = 2'd2;
	localparam logic [1:0] CMD_IDENT = 2'd3;

	localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
	localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [33:0] Q30_GAIN    = 34'sh026DD3B6A;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [15:0] first_angle;
		logic signed [15:0] second_angle;
		logic signed [15:0] third_angle;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} result_t;

	// Arctangent table in Q30, truncated.
	function automatic logic signed [33:0] atan_entry(input int i);
		logic signed [33:0] r;
		case (i)
			0: r = 34'sh03243F6A8;
			1: r = 34'sh01DAC6705;
			2: r = 34'sh00FADBAFC;
			3: r = 34'sh007F56EA6;
			4: r = 34'sh003FEAB76;
			5: r = 34'sh001FFD55B;
			6: r = 34'sh000FFFAAA;
			7: r = 34'sh0007FFF55;
			8: r = 34'sh0003FFFEA;
			9: r = 34'sh0001FFFFD;
			default: r = (34'sd1 <<< (30 - i)) - 34'sd1;
		endcase
		return r;
	endfunction

endpackage

FILE: src/rmfa_cordic.sv
// Pipelined sine/cosine: one range-reduction stage, one register per CORDIC
// iteration, and a final flip and rounding stage.
module rmfa_cordic #(
	parameter int COEF_WIDTH    = rmfa_pkg::COEF_WIDTH_DEF,
	parameter int CORDIC_STAGES = rmfa_pkg::CORDIC_STAGES_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [15:0]           angle,
	output logic signed [COEF_WIDTH-1:0] sin_o,
	output logic signed [COEF_WIDTH-1:0] cos_o
);
	localparam int F  = COEF_WIDTH - 2;
	localparam int SH = 30 - F;

	logic signed [33:0] z0;
	logic               flip0;
	logic signed [33:0] xs [0:CORDIC_STAGES];
	logic signed [33:0] ys [0:CORDIC_STAGES];
	logic signed [33:0] zs [0:CORDIC_STAGES];
	logic               fs [0:CORDIC_STAGES];
	logic signed [33:0] xf, yf;

	always_comb begin
		z0 = 34'(angle) <<< 17;
		flip0 = 1'b0;
		if (z0 > rmfa_pkg::Q30_HALF_PI) begin
			z0 = z0 - rmfa_pkg::Q30_PI;
			flip0 = 1'b1;
		end else if (z0 < -rmfa_pkg::Q30_HALF_PI) begin
			z0 = z0 + rmfa_pkg::Q30_PI;
			flip0 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xs[0] <= rmfa_pkg::Q30_GAIN;
			ys[0] <= '0;
			zs[0] <= z0;
			fs[0] <= flip0;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				fs[i+1] <= fs[i];
				if (zs[i] >= 0) begin
					xs[i+1] <= xs[i] - (ys[i] >>> i);
					ys[i+1] <= ys[i] + (xs[i] >>> i);
					zs[i+1] <= zs[i] - rmfa_pkg::atan_entry(i);
				end else begin
					xs[i+1] <= xs[i] + (ys[i] >>> i);
					ys[i+1] <= ys[i] - (xs[i] >>> i);
					zs[i+1] <= zs[i] + rmfa_pkg::atan_entry(i);
				end
			end
		end
	end

	always_comb begin
		xf = fs[CORDIC_STAGES] ? -xs[CORDIC_STAGES] : xs[CORDIC_STAGES];
		yf = fs[CORDIC_STAGES] ? -ys[CORDIC_STAGES] : ys[CORDIC_STAGES];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_o <= COEF_WIDTH'((yf + (34'sd1 <<< (SH - 1))) >>> SH);
			cos_o <= COEF_WIDTH'((xf + (34'sd1 <<< (SH - 1))) >>> SH);
		end
	end
endmodule

FILE: src/rotation_matrix_from_angles_unit.sv
// Throughput: one command per cycle; busy is held low, so start is always taken.
// The receiver cannot stall; each result shows for one cycle with done high.
// Reset (arst_n low, asynchronous) clears only the valid bits of the pipeline;
// data registers are not reset.
module rotation_matrix_from_angles_unit #(
	parameter int COEF_WIDTH    = rmfa_pkg::COEF_WIDTH_DEF,
	parameter int CORDIC_STAGES = rmfa_pkg::CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rmfa_pkg::cmd_t    cmd,
	output logic              done,
	output rmfa_pkg::result_t result
);
	localparam int W   = COEF_WIDTH;
	localparam int F   = W - 2;
	localparam int CL  = CORDIC_STAGES + 2;
	localparam int LAT = CL + 4;
	localparam int PW  = 2 * W + 2;

	typedef logic signed [W-1:0] coef_t;
	typedef logic signed [W+3:0] sum_t;

	// The pipeline never stalls, so every stage simply advances each cycle.
	logic [LAT-1:0] vld_q;
	logic           en;
	assign en   = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end
	assign done = vld_q[LAT-1];

	// Three sine/cosine pipelines, one per angle.
	coef_t s1, c1, s2, c2, s3, c3;
	rmfa_cordic #(.COEF_WIDTH(W), .CORDIC_STAGES(CORDIC_STAGES)) u_cor1 (
		.clk(clk), .en(en), .angle(cmd.first_angle), .sin_o(s1), .cos_o(c1));
	rmfa_cordic #(.COEF_WIDTH(W), .CORDIC_STAGES(CORDIC_STAGES)) u_cor2 (
		.clk(clk), .en(en), .angle(cmd.second_angle), .sin_o(s2), .cos_o(c2));
	rmfa_cordic #(.COEF_WIDTH(W), .CORDIC_STAGES(CORDIC_STAGES)) u_cor3 (
		.clk(clk), .en(en), .angle(cmd.third_angle), .sin_o(s3), .cos_o(c3));

	// Command and axis ride alongside the sine/cosine pipelines.
	logic [1:0]         cmd_d [0:CL];
	logic signed [15:0] ax_d [0:CL];
	logic signed [15:0] ay_d [0:CL];
	logic signed [15:0] az_d [0:CL];
	always_comb begin
		cmd_d[0] = cmd.command;
		ax_d[0]  = cmd.axis_x;
		ay_d[0]  = cmd.axis_y;
		az_d[0]  = cmd.axis_z;
	end
	for (genvar k = 0; k < CL; k++) begin : g_dly
		always_ff @(posedge clk) begin
			cmd_d[k+1] <= cmd_d[k];
			ax_d[k+1]  <= ax_d[k];
			ay_d[k+1]  <= ay_d[k];
			az_d[k+1]  <= az_d[k];
		end
	end

	function automatic coef_t mulq(input coef_t a, input coef_t b);
		logic signed [PW-1:0] p;
		p = (PW'(a) * PW'(b)) + (PW'(1) <<< (F - 1));
		return coef_t'(p >>> F);
	endfunction

	function automatic sum_t sx(input coef_t a);
		return sum_t'(a);
	endfunction

	// Stage s1: axis products (exact Q28), sin products, pair products.
	// One minus cosine reaches two near a half turn, and an axis far from unit
	// length can scale terms well past one, so these keep the wide format.
	logic [1:0]          cmd_s1;
	logic signed [31:0]  xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1;
	sum_t                xs_s1, ys_s1, zs_s1, omc_s1;
	coef_t               s1_s1, c1_s1, s2_s1, c2_s1, s3_s1, c3_s1, p1_s1, p2_s1;
	logic signed [47:0]  xs_w, ys_w, zs_w;

	always_comb begin
		xs_w = 48'(ax_d[CL]) * 48'(s1) + 48'sd8192;
		ys_w = 48'(ay_d[CL]) * 48'(s1) + 48'sd8192;
		zs_w = 48'(az_d[CL]) * 48'(s1) + 48'sd8192;
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd_d[CL];
		xx_s1  <= 32'(ax_d[CL]) * 32'(ax_d[CL]);
		yy_s1  <= 32'(ay_d[CL]) * 32'(ay_d[CL]);
		zz_s1  <= 32'(az_d[CL]) * 32'(az_d[CL]);
		xy_s1  <= 32'(ax_d[CL]) * 32'(ay_d[CL]);
		xz_s1  <= 32'(ax_d[CL]) * 32'(az_d[CL]);
		yz_s1  <= 32'(ay_d[CL]) * 32'(az_d[CL]);
		xs_s1  <= sum_t'(xs_w >>> 14);
		ys_s1  <= sum_t'(ys_w >>> 14);
		zs_s1  <= sum_t'(zs_w >>> 14);
		omc_s1 <= (sum_t'(1) <<< F) - sx(c1);
		s1_s1 <= s1; c1_s1 <= c1; s2_s1 <= s2; c2_s1 <= c2; s3_s1 <= s3; c3_s1 <= c3;
		// XYZ: sp*sy, cp*sy. YXZ: sy*sx, cy*sx.
		p1_s1 <= mulq(s1, s2);
		p2_s1 <= (cmd_d[CL] == rmfa_pkg::CMD_XYZ) ? mulq(c1, s2) : mulq(c2, s1);
	end

	// Stage s2: second-level products.
	function automatic sum_t mula(input logic signed [31:0] a, input sum_t b);
		logic signed [W+33:0] p;
		p = ((W+34)'(a) * (W+34)'(b)) + ((W+34)'(1) <<< 27);
		return sum_t'(p >>> 28);
	endfunction

	logic [1:0] cmd_s2;
	coef_t      t_s2 [0:11];
	sum_t       a_s2 [0:5];
	sum_t       xs_s2, ys_s2, zs_s2;
	coef_t      c1_s2, s1_s2, s2_s2;

	always_ff @(posedge clk) begin
		cmd_s2 <= cmd_s1;
		xs_s2 <= xs_s1; ys_s2 <= ys_s1; zs_s2 <= zs_s1;
		c1_s2 <= c1_s1; s1_s2 <= s1_s1; s2_s2 <= s2_s1;
		a_s2[0] <= mula(xx_s1, omc_s1);
		a_s2[1] <= mula(yy_s1, omc_s1);
		a_s2[2] <= mula(zz_s1, omc_s1);
		a_s2[3] <= mula(xy_s1, omc_s1);
		a_s2[4] <= mula(xz_s1, omc_s1);
		a_s2[5] <= mula(yz_s1, omc_s1);
		case (cmd_s1)
			rmfa_pkg::CMD_AXIS: begin
				for (int j = 0; j < 12; j++) t_s2[j] <= '0;
			end
			rmfa_pkg::CMD_XYZ: begin
				t_s2[0]  <= mulq(c2_s1, c3_s1);
				t_s2[1]  <= mulq(c2_s1, s3_s1);
				t_s2[2]  <= mulq(p1_s1, c3_s1);
				t_s2[3]  <= mulq(c1_s1, s3_s1);
				t_s2[4]  <= mulq(p1_s1, s3_s1);
				t_s2[5]  <= mulq(c1_s1, c3_s1);
				t_s2[6]  <= mulq(s1_s1, c2_s1);
				t_s2[7]  <= mulq(p2_s1, c3_s1);
				t_s2[8]  <= mulq(s1_s1, s3_s1);
				t_s2[9]  <= mulq(p2_s1, s3_s1);
				t_s2[10] <= mulq(s1_s1, c3_s1);
				t_s2[11] <= mulq(c1_s1, c2_s1);
			end
			default: begin
				t_s2[0]  <= mulq(c2_s1, c3_s1);
				t_s2[1]  <= mulq(p1_s1, s3_s1);
				t_s2[2]  <= mulq(c2_s1, s3_s1);
				t_s2[3]  <= mulq(p1_s1, c3_s1);
				t_s2[4]  <= mulq(s2_s1, c1_s1);
				t_s2[5]  <= mulq(c1_s1, s3_s1);
				t_s2[6]  <= mulq(c1_s1, c3_s1);
				t_s2[7]  <= mulq(s2_s1, c3_s1);
				t_s2[8]  <= mulq(p2_s1, s3_s1);
				t_s2[9]  <= mulq(s2_s1, s3_s1);
				t_s2[10] <= mulq(p2_s1, c3_s1);
				t_s2[11] <= mulq(c2_s1, c1_s1);
			end
		endcase
	end

	// Stage s3: sums in Q1.F with enough guard bits for out-of-range axes.
	sum_t m_s3 [0:8];

	always_ff @(posedge clk) begin
		case (cmd_s2)
			rmfa_pkg::CMD_AXIS: begin
				m_s3[0] <= a_s2[0] + sx(c1_s2);
				m_s3[1] <= a_s2[3] - zs_s2;
				m_s3[2] <= a_s2[4] + ys_s2;
				m_s3[3] <= a_s2[3] + zs_s2;
				m_s3[4] <= a_s2[1] + sx(c1_s2);
				m_s3[5] <= a_s2[5] - xs_s2;
				m_s3[6] <= a_s2[4] - ys_s2;
				m_s3[7] <= a_s2[5] + xs_s2;
				m_s3[8] <= a_s2[2] + sx(c1_s2);
			end
			rmfa_pkg::CMD_XYZ: begin
				m_s3[0] <= sx(t_s2[0]);
				m_s3[1] <= -sx(t_s2[1]);
				m_s3[2] <= sx(s2_s2);
				m_s3[3] <= sx(t_s2[2]) + sx(t_s2[3]);
				m_s3[4] <= -sx(t_s2[4]) + sx(t_s2[5]);
				m_s3[5] <= -sx(t_s2[6]);
				m_s3[6] <= -sx(t_s2[7]) + sx(t_s2[8]);
				m_s3[7] <= sx(t_s2[9]) + sx(t_s2[10]);
				m_s3[8] <= sx(t_s2[11]);
			end
			rmfa_pkg::CMD_YXZ: begin
				m_s3[0] <= sx(t_s2[0]) + sx(t_s2[1]);
				m_s3[1] <= -sx(t_s2[2]) + sx(t_s2[3]);
				m_s3[2] <= sx(t_s2[4]);
				m_s3[3] <= sx(t_s2[5]);
				m_s3[4] <= sx(t_s2[6]);
				m_s3[5] <= -sx(s1_s2);
				m_s3[6] <= -sx(t_s2[7]) + sx(t_s2[8]);
				m_s3[7] <= sx(t_s2[9]) + sx(t_s2[10]);
				m_s3[8] <= sx(t_s2[11]);
			end
			default: begin
				for (int j = 0; j < 9; j++)
					m_s3[j] <= (j % 4 == 0) ? (sum_t'(1) <<< F) : '0;
			end
		endcase
	end

	// Stage s4: rescale to Q1.14 and saturate.
	function automatic logic signed [15:0] to_out(input sum_t v);
		logic signed [W+17:0] r;
		if (F >= 14) begin
			if (F == 14) r = (W+18)'(v);
			else r = ((W+18)'(v) + ((W+18)'(1) <<< (F - 15))) >>> (F - 14);
		end else begin
			r = (W+18)'(v) <<< (14 - F);
		end
		if (r > 32767) return 16'sh7FFF;
		if (r < -32768) return 16'sh8000;
		return 16'(r);
	endfunction

	rmfa_pkg::result_t res_s4;
	always_ff @(posedge clk) begin
		res_s4.m00 <= to_out(m_s3[0]);
		res_s4.m01 <= to_out(m_s3[1]);
		res_s4.m02 <= to_out(m_s3[2]);
		res_s4.m10 <= to_out(m_s3[3]);
		res_s4.m11 <= to_out(m_s3[4]);
		res_s4.m12 <= to_out(m_s3[5]);
		res_s4.m20 <= to_out(m_s3[6]);
		res_s4.m21 <= to_out(m_s3[7]);
		res_s4.m22 <= to_out(m_s3[8]);
	end
	assign result = res_s4;
endmodule

FILE: src/rmfa_checker.sv
module rmfa_checker #(
	parameter int LAT = rmfa_pkg::CORDIC_STAGES_DEF + 6
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input rmfa_pkg::result_t result
);
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_no_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(arst_n))
		else $error("done right after reset");
	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result))
		else $error("unknown result");
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("done without a start transfer");
endmodule

bind rotation_matrix_from_angles_unit rmfa_checker #(.LAT(LAT)) u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .result(result));

FILE: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COEF_W   = rmfa_pkg::COEF_WIDTH_DEF;
	localparam int STAGES   = rmfa_pkg::CORDIC_STAGES_DEF;
	localparam int FRAC     = COEF_W - 2;
	localparam int LATENCY  = STAGES + 6;
	localparam int ANG_MAX  = 25736;
	localparam int UNIT     = 16384;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	rmfa_pkg::cmd_t    cmd;
	logic              done;
	rmfa_pkg::result_t result;

	// Matrices the block owes us, oldest first.
	rmfa_pkg::result_t pending_matrices[$];
	int                error_count;
	bit                gaps_enabled;

	rotation_matrix_from_angles_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #2 clk = ~clk;

	// Floor shift on a signed 64-bit value; >>> on a signed operand is arithmetic.
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	// Round half up: add half an LSB, then shift down.
	function automatic longint round_shift(longint v, int s);
		if (s == 0) begin
			return v;
		end
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint arctan_q30(int i);
		case (i)
			0: return 64'h3243F6A8;
			1: return 64'h1DAC6705;
			2: return 64'h0FADBAFC;
			3: return 64'h07F56EA6;
			4: return 64'h03FEAB76;
			5: return 64'h01FFD55B;
			6: return 64'h00FFFAAA;
			7: return 64'h007FFF55;
			8: return 64'h003FFFEA;
			9: return 64'h001FFFFD;
			default: return (longint'(1) <<< (30 - i)) - 1;
		endcase
	endfunction

	// Sine and cosine of a Q3.13 angle, returned in the coefficient format.
	// The angle is folded by one half turn into [-pi/2, pi/2] before the
	// rotation-mode iterations, and the results are negated if it was folded.
	task automatic sine_cosine(input logic signed [15:0] angle, output longint s,
			output longint c);
		longint z;
		longint x;
		longint y;
		longint nx;
		bit     folded;
		z = longint'(angle) * 131072;
		x = 64'h26DD3B6A;
		y = 0;
		folded = 0;
		if (z > 64'sd1686629713) begin
			z = z - 64'sd3373259426;
			folded = 1;
		end else if (z < -64'sd1686629713) begin
			z = z + 64'sd3373259426;
			folded = 1;
		end
		for (int i = 0; i < STAGES && i < 30; i++) begin
			if (z >= 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z = z - arctan_q30(i);
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z = z + arctan_q30(i);
			end
			x = nx;
		end
		if (folded) begin
			x = -x;
			y = -y;
		end
		s = round_shift(y, 30 - FRAC);
		c = round_shift(x, 30 - FRAC);
	endtask

	function automatic longint coef_mul(longint a, longint b);
		return round_shift(a * b, FRAC);
	endfunction

	function automatic logic signed [15:0] to_q14(longint v);
		longint r;
		if (FRAC >= 14) begin
			r = round_shift(v, FRAC - 14);
		end else begin
			r = v * (longint'(1) <<< (14 - FRAC));
		end
		if (r > 32767) begin
			r = 32767;
		end
		if (r < -32768) begin
			r = -32768;
		end
		return r[15:0];
	endfunction

	// Expected rotation matrix for one command.
	task automatic predict_rotation(input rmfa_pkg::cmd_t c,
			output rmfa_pkg::result_t mat);
		longint m[9];
		longint one;
		longint s1, c1, s2, c2, s3, c3;
		longint x, y, z, omc, xym, xzm, yzm, xs, ys, zs, p, q;
		one = longint'(1) <<< FRAC;
		case (c.command)
			rmfa_pkg::CMD_AXIS: begin
				x = c.axis_x;
				y = c.axis_y;
				z = c.axis_z;
				sine_cosine(c.first_angle, s1, c1);
				omc = one - c1;
				xym = round_shift(x * y * omc, 28);
				xzm = round_shift(x * z * omc, 28);
				yzm = round_shift(y * z * omc, 28);
				xs = round_shift(x * s1, 14);
				ys = round_shift(y * s1, 14);
				zs = round_shift(z * s1, 14);
				m[0] = round_shift(x * x * omc, 28) + c1;
				m[1] = xym - zs;
				m[2] = xzm + ys;
				m[3] = xym + zs;
				m[4] = round_shift(y * y * omc, 28) + c1;
				m[5] = yzm - xs;
				m[6] = xzm - ys;
				m[7] = yzm + xs;
				m[8] = round_shift(z * z * omc, 28) + c1;
			end
			rmfa_pkg::CMD_XYZ: begin
				sine_cosine(c.first_angle, s1, c1);
				sine_cosine(c.second_angle, s2, c2);
				sine_cosine(c.third_angle, s3, c3);
				p = coef_mul(s1, s2);
				q = coef_mul(c1, s2);
				m[0] = coef_mul(c2, c3);
				m[1] = -coef_mul(c2, s3);
				m[2] = s2;
				m[3] = coef_mul(p, c3) + coef_mul(c1, s3);
				m[4] = -coef_mul(p, s3) + coef_mul(c1, c3);
				m[5] = -coef_mul(s1, c2);
				m[6] = -coef_mul(q, c3) + coef_mul(s1, s3);
				m[7] = coef_mul(q, s3) + coef_mul(s1, c3);
				m[8] = coef_mul(c1, c2);
			end
			rmfa_pkg::CMD_YXZ: begin
				sine_cosine(c.first_angle, s1, c1);
				sine_cosine(c.second_angle, s2, c2);
				sine_cosine(c.third_angle, s3, c3);
				p = coef_mul(s2, s1);
				q = coef_mul(c2, s1);
				m[0] = coef_mul(c2, c3) + coef_mul(p, s3);
				m[1] = -coef_mul(c2, s3) + coef_mul(p, c3);
				m[2] = coef_mul(s2, c1);
				m[3] = coef_mul(c1, s3);
				m[4] = coef_mul(c1, c3);
				m[5] = -s1;
				m[6] = -coef_mul(s2, c3) + coef_mul(q, s3);
				m[7] = coef_mul(s2, s3) + coef_mul(q, c3);
				m[8] = coef_mul(c2, c1);
			end
			default: begin
				for (int k = 0; k < 9; k++) begin
					m[k] = (k % 4 == 0) ? one : 0;
				end
			end
		endcase
		mat.m00 = to_q14(m[0]);
		mat.m01 = to_q14(m[1]);
		mat.m02 = to_q14(m[2]);
		mat.m10 = to_q14(m[3]);
		mat.m11 = to_q14(m[4]);
		mat.m12 = to_q14(m[5]);
		mat.m20 = to_q14(m[6]);
		mat.m21 = to_q14(m[7]);
		mat.m22 = to_q14(m[8]);
	endtask

	// Drives one command and holds it until the block takes the transfer.
	// Start stays high between back-to-back commands; it is lowered only
	// when an idle burst follows or the stimulus ends.
	task automatic send_command(input rmfa_pkg::cmd_t c);
		rmfa_pkg::result_t mat;
		int                gap;
		if (gaps_enabled && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		predict_rotation(c, mat);
		pending_matrices.push_back(mat);
	endtask

	task automatic end_of_burst();
		start <= 1'b0;
	endtask

	function automatic logic signed [15:0] random_angle();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
			default: return 16'($signed($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX);
		endcase
	endfunction

	function automatic logic signed [15:0] random_axis_component();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 2 * UNIT)) - UNIT);
		endcase
	endfunction

	function automatic rmfa_pkg::cmd_t make_command(logic [1:0] op, int a1, int a2,
			int a3, int ax, int ay, int az);
		rmfa_pkg::cmd_t c;
		c.command      = op;
		c.first_angle  = 16'(a1);
		c.second_angle = 16'(a2);
		c.third_angle  = 16'(a3);
		c.axis_x       = 16'(ax);
		c.axis_y       = 16'(ay);
		c.axis_z       = 16'(az);
		return c;
	endfunction

	// Axis, XYZ and YXZ modes at zero and at the angle extremes; axis and XYZ also at the folding boundary.
	task automatic test_directed_modes();
		send_command(make_command(rmfa_pkg::CMD_AXIS, 0, 0, 0, UNIT, 0, 0));
		send_command(make_command(rmfa_pkg::CMD_AXIS, ANG_MAX, 0, 0, 0, 0, UNIT));
		send_command(make_command(rmfa_pkg::CMD_AXIS, -ANG_MAX, 0, 0, 0, UNIT, 0));
		send_command(make_command(rmfa_pkg::CMD_AXIS, 12868, -1, 1, 9459, 9459, 9459));
		send_command(make_command(rmfa_pkg::CMD_XYZ, 0, 0, 0, 0, 0, 0));
		send_command(make_command(rmfa_pkg::CMD_XYZ, ANG_MAX, -ANG_MAX, ANG_MAX,
			0, 0, 0));
		send_command(make_command(rmfa_pkg::CMD_XYZ, 12868, 12869, -12869, -1, -1, -1));
		send_command(make_command(rmfa_pkg::CMD_YXZ, 0, 0, 0, 0, 0, 0));
		send_command(make_command(rmfa_pkg::CMD_YXZ, -ANG_MAX, ANG_MAX, -ANG_MAX,
			0, 0, 0));
		send_command(make_command(rmfa_pkg::CMD_YXZ, 6434, -6434, 3217, 0, 0, 0));
		end_of_burst();
	endtask

	// The unused command code must give the identity whatever the fields hold.
	task automatic test_identity_command();
		send_command(make_command(rmfa_pkg::CMD_IDENT, 0, 0, 0, 0, 0, 0));
		send_command(make_command(rmfa_pkg::CMD_IDENT, -1, -1, -1, -1, -1, -1));
		end_of_burst();
	endtask

	// Angles beyond +-pi and axes that are far from unit length or at the
	// raw 16-bit extremes, so the axis-mode outputs saturate.
	task automatic test_out_of_range();
		send_command(make_command(rmfa_pkg::CMD_AXIS, 32767, 0, 0, 32767, 32767, 32767));
		send_command(make_command(rmfa_pkg::CMD_AXIS, -32768, 0, 0, -32768, -32768,
			-32768));
		send_command(make_command(rmfa_pkg::CMD_AXIS, 25736, 0, 0, 32767, -32768, 16384));
		send_command(make_command(rmfa_pkg::CMD_XYZ, 32767, -32768, 32767, 0, 0, 0));
		send_command(make_command(rmfa_pkg::CMD_YXZ, -32768, 32767, -32768, 0, 0, 0));
		end_of_burst();
	endtask

	task automatic test_random_commands(input int count);
		rmfa_pkg::cmd_t c;
		for (int n = 0; n < count; n++) begin
			c.command      = ($urandom_range(0, 19) == 0) ? rmfa_pkg::CMD_IDENT
				: 2'($urandom_range(0, 2));
			c.first_angle  = random_angle();
			c.second_angle = random_angle();
			c.third_angle  = random_angle();
			c.axis_x       = random_axis_component();
			c.axis_y       = random_axis_component();
			c.axis_z       = random_axis_component();
			send_command(c);
		end
		end_of_burst();
	endtask

	// Every done strobe is one transfer that must match the oldest prediction.
	always @(posedge clk) begin
		rmfa_pkg::result_t exp_m;
		if (arst_n && done) begin
			if (pending_matrices.size() == 0) begin
				$error("matrix arrived with none expected");
				error_count++;
			end else begin
				exp_m = pending_matrices.pop_front();
				if (result.m00 !== exp_m.m00) begin
					$error("m00 expected %0d actual %0d", exp_m.m00, result.m00);
					error_count++;
				end
				if (result.m01 !== exp_m.m01) begin
					$error("m01 expected %0d actual %0d", exp_m.m01, result.m01);
					error_count++;
				end
				if (result.m02 !== exp_m.m02) begin
					$error("m02 expected %0d actual %0d", exp_m.m02, result.m02);
					error_count++;
				end
				if (result.m10 !== exp_m.m10) begin
					$error("m10 expected %0d actual %0d", exp_m.m10, result.m10);
					error_count++;
				end
				if (result.m11 !== exp_m.m11) begin
					$error("m11 expected %0d actual %0d", exp_m.m11, result.m11);
					error_count++;
				end
				if (result.m12 !== exp_m.m12) begin
					$error("m12 expected %0d actual %0d", exp_m.m12, result.m12);
					error_count++;
				end
				if (result.m20 !== exp_m.m20) begin
					$error("m20 expected %0d actual %0d", exp_m.m20, result.m20);
					error_count++;
				end
				if (result.m21 !== exp_m.m21) begin
					$error("m21 expected %0d actual %0d", exp_m.m21, result.m21);
					error_count++;
				end
				if (result.m22 !== exp_m.m22) begin
					$error("m22 expected %0d actual %0d", exp_m.m22, result.m22);
					error_count++;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		error_count = 0;
		gaps_enabled = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_modes();
		test_identity_command();
		test_out_of_range();
		test_random_commands(420);
		// The last stretch runs back to back with no idle cycles.
		gaps_enabled = 1'b0;
		test_random_commands(110);

		while (pending_matrices.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 4) @(posedge clk);

		if (error_count == 0 && pending_matrices.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Generous watchdog well beyond the slowest legal run.
	initial begin
		#400us;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
